@@ sv/rdu_pkg.sv @@
package rdu_pkg;

  // Vector component format
  localparam int CW = 20;
  localparam int TF = 16;

  // Derived arithmetic widths
  localparam int PW   = 2 * CW;
  localparam int DOTW = PW + 2;
  localparam int NUMW = DOTW + 1;
  localparam int DETW = PW + 1;
  localparam int TW   = 32;
  localparam int TPW  = TW + CW;
  localparam int OFW  = TPW - TF + 2;

  // Divider geometry: quotient bits, operand widths, latency
  localparam int DIV_QB  = 33;
  localparam int DIV_NW  = NUMW + TF + 1;
  localparam int DIV_DW  = DOTW + 1;
  localparam int DIV_NM  = DIV_NW - 1;
  localparam int DIV_DM  = DIV_DW - 1;
  localparam int DIV_LAT = DIV_QB + 1;

  // Status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_DIFF    = 3'd1;
  localparam logic [2:0] ST_PLANE_FAIL = 3'd2;
  localparam logic [2:0] ST_SINGULAR   = 3'd5;

  typedef logic [2:0][CW-1:0] vec_t;

endpackage

@@ sv/ray_differential_uv_solve_top.sv @@
// Ray-differential texture footprint: each word carries a hit point, its normal, dP/du,
// dP/dv and the x and y offset rays; the result word gives both offset-hit deltas and
// du/dx, dv/dx, du/dy, dv/dy in Q16.16 plus a status code. The pipeline takes one word
// every cycle unless the output stalls; its depth comes mostly from two banks of
// restoring dividers (a prepare stage plus 33 one-bit steps), first for the plane
// parameter, then for the 2x2 solves.
// A stall on the output freezes the whole pipeline, so nothing is lost or repeated.
// Write det_threshold through the configuration channel only while no word is in flight.
module ray_differential_uv_solve_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          has_diff,
  input  logic [3*rdu_pkg::CW-1:0]      hit_point,
  input  logic [3*rdu_pkg::CW-1:0]      surface_normal,
  input  logic [3*rdu_pkg::CW-1:0]      tangent_u,
  input  logic [3*rdu_pkg::CW-1:0]      tangent_v,
  input  logic [3*rdu_pkg::CW-1:0]      x_ray_origin,
  input  logic [3*rdu_pkg::CW-1:0]      x_ray_dir,
  input  logic [3*rdu_pkg::CW-1:0]      y_ray_origin,
  input  logic [3*rdu_pkg::CW-1:0]      y_ray_dir,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [3*rdu_pkg::CW-1:0]      dpos_dx,
  output logic [3*rdu_pkg::CW-1:0]      dpos_dy,
  output logic signed [31:0]            du_dx,
  output logic signed [31:0]            dv_dx,
  output logic signed [31:0]            du_dy,
  output logic signed [31:0]            dv_dy,
  output logic [2:0]                    status
);

  typedef struct packed {
    logic                                   v;
    logic                                   hd;
    rdu_pkg::vec_t                          ox, rx, oy, ry, p;
    logic [2:0][rdu_pkg::PW-1:0]            np, nox, nrx, noy, nry;
    logic [3:0][rdu_pkg::CW-1:0]            a;
    logic [1:0]                             d0, d1;
    logic [rdu_pkg::PW-1:0]                 m0, m1;
  } s1_t;

  typedef struct packed {
    logic                                   v;
    logic                                   hd;
    rdu_pkg::vec_t                          ox, rx, oy, ry, p;
    logic [3:0][rdu_pkg::CW-1:0]            a;
    logic [1:0]                             d0, d1;
    logic [rdu_pkg::DETW-1:0]               det;
    logic                                   denx_z, deny_z;
  } s2_t;

  typedef struct packed {
    logic                                   v;
    logic                                   hd;
    logic                                   fail;
    logic                                   sing;
    rdu_pkg::vec_t                          ox, rx, oy, ry, p;
    logic [3:0][rdu_pkg::CW-1:0]            a;
    logic [1:0]                             d0, d1;
    logic [rdu_pkg::DETW-1:0]               det;
    logic [rdu_pkg::TW-1:0]                 tx, ty;
  } s4_t;

  typedef struct packed {
    logic                                   v;
    logic                                   hd;
    logic                                   fail;
    logic                                   sing;
    rdu_pkg::vec_t                          ox, oy, p;
    logic [3:0][rdu_pkg::CW-1:0]            a;
    logic [1:0]                             d0, d1;
    logic [rdu_pkg::DETW-1:0]               det;
    logic [2:0][rdu_pkg::TPW-1:0]           px, py;
  } s5_t;

  typedef struct packed {
    logic                                   v;
    logic                                   hd;
    logic                                   fail;
    logic                                   sing;
    rdu_pkg::vec_t                          offx, offy;
    logic [3:0][rdu_pkg::CW-1:0]            a;
    logic [1:0]                             d0, d1;
    logic [rdu_pkg::DETW-1:0]               det;
  } s6_t;

  typedef struct packed {
    logic                                   v;
    logic                                   hd;
    logic                                   fail;
    logic                                   sing;
    rdu_pkg::vec_t                          offx, offy;
  } side_t;

  typedef struct packed {
    side_t                                  sd;
    logic [rdu_pkg::DETW-1:0]               det;
    logic [3:0][rdu_pkg::PW-1:0]            mx, my;
  } s7_t;

  typedef struct packed {
    side_t                                  sd;
    logic [rdu_pkg::DETW-1:0]               det;
    logic [3:0][rdu_pkg::DETW-1:0]          cof;
  } s8_t;

  function automatic logic [rdu_pkg::CW:0] abs_c(input logic [rdu_pkg::CW-1:0] x);
    logic signed [rdu_pkg::CW:0] e;
    e = {x[rdu_pkg::CW-1], x};
    return e[rdu_pkg::CW] ? (rdu_pkg::CW+1)'(-e) : e;
  endfunction

  function automatic logic signed [rdu_pkg::DOTW-1:0] sum3(
    input logic [2:0][rdu_pkg::PW-1:0] x);
    return rdu_pkg::DOTW'($signed(x[0])) + rdu_pkg::DOTW'($signed(x[1]))
         + rdu_pkg::DOTW'($signed(x[2]));
  endfunction

  function automatic logic [rdu_pkg::CW-1:0] sat_c(input logic signed [rdu_pkg::OFW-1:0] x);
    logic signed [rdu_pkg::OFW-1:0] hi;
    logic signed [rdu_pkg::OFW-1:0] lo;
    hi = rdu_pkg::OFW'(2 ** (rdu_pkg::CW - 1) - 1);
    lo = -hi - rdu_pkg::OFW'(1);
    if (x > hi) return hi[rdu_pkg::CW-1:0];
    if (x < lo) return lo[rdu_pkg::CW-1:0];
    return x[rdu_pkg::CW-1:0];
  endfunction

  function automatic logic [31:0] sat_q(input logic signed [rdu_pkg::DIV_QB:0] q,
                                        input logic neg, input logic ovf);
    logic fits;
    fits = (q[rdu_pkg::DIV_QB:31] == '0) || (q[rdu_pkg::DIV_QB:31] == '1);
    if (ovf) return neg ? 32'h8000_0000 : 32'h7fff_ffff;
    if (!fits) return q[rdu_pkg::DIV_QB] ? 32'h8000_0000 : 32'h7fff_ffff;
    return q[31:0];
  endfunction

  logic [31:0] det_threshold;
  logic        adv;

  s1_t   s1, s1_next;
  s2_t   s2, s2_next;
  logic signed [rdu_pkg::NUMW-1:0] numx, numy, numx_next, numy_next;
  logic signed [rdu_pkg::DOTW-1:0] denx, deny, denx_next, deny_next;
  s2_t   dl1 [rdu_pkg::DIV_LAT];
  s4_t   s4, s4_next;
  s5_t   s5, s5_next;
  s6_t   s6, s6_next;
  s7_t   s7, s7_next;
  s8_t   s8, s8_next;
  side_t dl2 [rdu_pkg::DIV_LAT];

  logic signed [rdu_pkg::DIV_QB:0] q1 [2];
  logic                            q1_neg [2];
  logic                            q1_ovf [2];
  logic signed [rdu_pkg::DIV_QB:0] q2 [4];
  logic                            q2_neg [4];
  logic                            q2_ovf [4];

  logic [3*rdu_pkg::CW-1:0] dpos_dx_next, dpos_dy_next;
  logic [31:0]              du_dx_next, dv_dx_next, du_dy_next, dv_dy_next;
  logic [2:0]               status_next;

  // Whole pipeline moves when the output register is free or being drained
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  // Hold the threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      det_threshold <= 32'd1;
    end else if (cfg_valid) begin
      det_threshold <= cfg_data;
    end
  end

  // Stage 1: dot-product terms, dominant-axis pick, determinant products
  always_comb begin
    rdu_pkg::vec_t n, p, tu, tv, ox, rx, oy, ry;
    logic [rdu_pkg::CW:0] axn, ayn, azn;
    n  = surface_normal;
    p  = hit_point;
    tu = tangent_u;
    tv = tangent_v;
    ox = x_ray_origin;
    rx = x_ray_dir;
    oy = y_ray_origin;
    ry = y_ray_dir;
    s1_next    = '0;
    s1_next.v  = in_valid;
    s1_next.hd = has_diff;
    s1_next.ox = ox;
    s1_next.rx = rx;
    s1_next.oy = oy;
    s1_next.ry = ry;
    s1_next.p  = p;
    for (int i = 0; i < 3; i++) begin
      s1_next.np[i]  = $signed(n[i]) * $signed(p[i]);
      s1_next.nox[i] = $signed(n[i]) * $signed(ox[i]);
      s1_next.nrx[i] = $signed(n[i]) * $signed(rx[i]);
      s1_next.noy[i] = $signed(n[i]) * $signed(oy[i]);
      s1_next.nry[i] = $signed(n[i]) * $signed(ry[i]);
    end
    axn = abs_c(n[0]);
    ayn = abs_c(n[1]);
    azn = abs_c(n[2]);
    if (axn > ayn && axn > azn) begin
      s1_next.d0 = 2'd1;
      s1_next.d1 = 2'd2;
    end else if (ayn > azn) begin
      s1_next.d0 = 2'd0;
      s1_next.d1 = 2'd2;
    end else begin
      s1_next.d0 = 2'd0;
      s1_next.d1 = 2'd1;
    end
    s1_next.a[0] = tu[s1_next.d0];
    s1_next.a[1] = tv[s1_next.d0];
    s1_next.a[2] = tu[s1_next.d1];
    s1_next.a[3] = tv[s1_next.d1];
    s1_next.m0 = $signed(s1_next.a[0]) * $signed(s1_next.a[3]);
    s1_next.m1 = $signed(s1_next.a[1]) * $signed(s1_next.a[2]);
  end

  // Stage 2: plane numerators and denominators, determinant
  always_comb begin
    logic signed [rdu_pkg::DOTW-1:0] d;
    d = sum3(s1.np);
    numx_next = rdu_pkg::NUMW'(d) - rdu_pkg::NUMW'(sum3(s1.nox));
    numy_next = rdu_pkg::NUMW'(d) - rdu_pkg::NUMW'(sum3(s1.noy));
    denx_next = sum3(s1.nrx);
    deny_next = sum3(s1.nry);
    s2_next.v      = s1.v;
    s2_next.hd     = s1.hd;
    s2_next.ox     = s1.ox;
    s2_next.rx     = s1.rx;
    s2_next.oy     = s1.oy;
    s2_next.ry     = s1.ry;
    s2_next.p      = s1.p;
    s2_next.a      = s1.a;
    s2_next.d0     = s1.d0;
    s2_next.d1     = s1.d1;
    s2_next.det    = rdu_pkg::DETW'($signed(s1.m0)) - rdu_pkg::DETW'($signed(s1.m1));
    s2_next.denx_z = denx_next == '0;
    s2_next.deny_z = deny_next == '0;
  end

  // Plane parameter t = num * 2^16 / den for both rays
  rdu_div u_div_tx (
    .clk (clk),
    .adv (adv),
    .num (rdu_pkg::DIV_NW'($signed({numx, rdu_pkg::TF'(0)}))),
    .den (rdu_pkg::DIV_DW'(denx)),
    .quo (q1[0]),
    .neg (q1_neg[0]),
    .ovf (q1_ovf[0])
  );

  rdu_div u_div_ty (
    .clk (clk),
    .adv (adv),
    .num (rdu_pkg::DIV_NW'($signed({numy, rdu_pkg::TF'(0)}))),
    .den (rdu_pkg::DIV_DW'(deny)),
    .quo (q1[1]),
    .neg (q1_neg[1]),
    .ovf (q1_ovf[1])
  );

  // Stage 4: range-check t, classify the determinant
  always_comb begin
    s2_t  z;
    logic fx, fy;
    logic [rdu_pkg::DETW-1:0] adet;
    z    = dl1[rdu_pkg::DIV_LAT-1];
    fx   = z.denx_z || q1_ovf[0] ||
           !((q1[0][rdu_pkg::DIV_QB:31] == '0) || (q1[0][rdu_pkg::DIV_QB:31] == '1));
    fy   = z.deny_z || q1_ovf[1] ||
           !((q1[1][rdu_pkg::DIV_QB:31] == '0) || (q1[1][rdu_pkg::DIV_QB:31] == '1));
    adet = z.det[rdu_pkg::DETW-1] ? rdu_pkg::DETW'(-$signed(z.det)) : z.det;
    s4_next.v    = z.v;
    s4_next.hd   = z.hd;
    s4_next.fail = fx || fy;
    s4_next.sing = (z.det == '0) || (adet < rdu_pkg::DETW'(det_threshold));
    s4_next.ox   = z.ox;
    s4_next.rx   = z.rx;
    s4_next.oy   = z.oy;
    s4_next.ry   = z.ry;
    s4_next.p    = z.p;
    s4_next.a    = z.a;
    s4_next.d0   = z.d0;
    s4_next.d1   = z.d1;
    s4_next.det  = z.det;
    s4_next.tx   = q1[0][31:0];
    s4_next.ty   = q1[1][31:0];
  end

  // Stage 5: t times each direction component
  always_comb begin
    s5_next.v    = s4.v;
    s5_next.hd   = s4.hd;
    s5_next.fail = s4.fail;
    s5_next.sing = s4.sing;
    s5_next.ox   = s4.ox;
    s5_next.oy   = s4.oy;
    s5_next.p    = s4.p;
    s5_next.a    = s4.a;
    s5_next.d0   = s4.d0;
    s5_next.d1   = s4.d1;
    s5_next.det  = s4.det;
    for (int i = 0; i < 3; i++) begin
      s5_next.px[i] = $signed(s4.tx) * $signed(s4.rx[i]);
      s5_next.py[i] = $signed(s4.ty) * $signed(s4.ry[i]);
    end
  end

  // Stage 6: offset hit minus hit point, floored and saturated
  always_comb begin
    logic signed [rdu_pkg::TPW-1:0] shx, shy;
    logic signed [rdu_pkg::OFW-1:0] sx, sy;
    s6_next.v    = s5.v;
    s6_next.hd   = s5.hd;
    s6_next.fail = s5.fail;
    s6_next.sing = s5.sing;
    s6_next.a    = s5.a;
    s6_next.d0   = s5.d0;
    s6_next.d1   = s5.d1;
    s6_next.det  = s5.det;
    for (int i = 0; i < 3; i++) begin
      shx = $signed(s5.px[i]) >>> rdu_pkg::TF;
      shy = $signed(s5.py[i]) >>> rdu_pkg::TF;
      sx  = rdu_pkg::OFW'($signed(s5.ox[i])) + shx[rdu_pkg::OFW-1:0]
          - rdu_pkg::OFW'($signed(s5.p[i]));
      sy  = rdu_pkg::OFW'($signed(s5.oy[i])) + shy[rdu_pkg::OFW-1:0]
          - rdu_pkg::OFW'($signed(s5.p[i]));
      s6_next.offx[i] = sat_c(sx);
      s6_next.offy[i] = sat_c(sy);
    end
  end

  // Stage 7: cofactor products on the projected offsets
  always_comb begin
    logic [rdu_pkg::CW-1:0] bx0, bx1, by0, by1;
    bx0 = s6.offx[s6.d0];
    bx1 = s6.offx[s6.d1];
    by0 = s6.offy[s6.d0];
    by1 = s6.offy[s6.d1];
    s7_next.sd.v    = s6.v;
    s7_next.sd.hd   = s6.hd;
    s7_next.sd.fail = s6.fail;
    s7_next.sd.sing = s6.sing;
    s7_next.sd.offx = s6.offx;
    s7_next.sd.offy = s6.offy;
    s7_next.det     = s6.det;
    s7_next.mx[0] = $signed(s6.a[3]) * $signed(bx0);
    s7_next.mx[1] = $signed(s6.a[1]) * $signed(bx1);
    s7_next.mx[2] = $signed(s6.a[0]) * $signed(bx1);
    s7_next.mx[3] = $signed(s6.a[2]) * $signed(bx0);
    s7_next.my[0] = $signed(s6.a[3]) * $signed(by0);
    s7_next.my[1] = $signed(s6.a[1]) * $signed(by1);
    s7_next.my[2] = $signed(s6.a[0]) * $signed(by1);
    s7_next.my[3] = $signed(s6.a[2]) * $signed(by0);
  end

  // Stage 8: cofactors
  always_comb begin
    s8_next.sd  = s7.sd;
    s8_next.det = s7.det;
    s8_next.cof[0] = rdu_pkg::DETW'($signed(s7.mx[0])) - rdu_pkg::DETW'($signed(s7.mx[1]));
    s8_next.cof[1] = rdu_pkg::DETW'($signed(s7.mx[2])) - rdu_pkg::DETW'($signed(s7.mx[3]));
    s8_next.cof[2] = rdu_pkg::DETW'($signed(s7.my[0])) - rdu_pkg::DETW'($signed(s7.my[1]));
    s8_next.cof[3] = rdu_pkg::DETW'($signed(s7.my[2])) - rdu_pkg::DETW'($signed(s7.my[3]));
  end

  // Solve quotients cofactor * 2^16 / det
  for (genvar j = 0; j < 4; j++) begin : g_solve
    rdu_div u_div_uv (
      .clk (clk),
      .adv (adv),
      .num (rdu_pkg::DIV_NW'($signed({s8.cof[j], rdu_pkg::TF'(0)}))),
      .den (rdu_pkg::DIV_DW'($signed(s8.det))),
      .quo (q2[j]),
      .neg (q2_neg[j]),
      .ovf (q2_ovf[j])
    );
  end

  // Stage 9: saturate, zero special cases, build status
  always_comb begin
    side_t z;
    logic  zall, zuv;
    z    = dl2[rdu_pkg::DIV_LAT-1];
    zall = !z.hd || z.fail;
    zuv  = zall || z.sing;
    dpos_dx_next = zall ? '0 : z.offx;
    dpos_dy_next = zall ? '0 : z.offy;
    du_dx_next   = zuv ? '0 : sat_q(q2[0], q2_neg[0], q2_ovf[0]);
    dv_dx_next   = zuv ? '0 : sat_q(q2[1], q2_neg[1], q2_ovf[1]);
    du_dy_next   = zuv ? '0 : sat_q(q2[2], q2_neg[2], q2_ovf[2]);
    dv_dy_next   = zuv ? '0 : sat_q(q2[3], q2_neg[3], q2_ovf[3]);
    if (!z.hd) begin
      status_next = rdu_pkg::ST_NO_DIFF;
    end else if (z.fail) begin
      status_next = rdu_pkg::ST_PLANE_FAIL;
    end else if (z.sing) begin
      status_next = rdu_pkg::ST_SINGULAR;
    end else begin
      status_next = rdu_pkg::ST_OK;
    end
  end

  // Advance all stages together; reset drops valid bits only
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.v      <= 1'b0;
      s2.v      <= 1'b0;
      s4.v      <= 1'b0;
      s5.v      <= 1'b0;
      s6.v      <= 1'b0;
      s7.sd.v   <= 1'b0;
      s8.sd.v   <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < rdu_pkg::DIV_LAT; k++) begin
        dl1[k].v <= 1'b0;
        dl2[k].v <= 1'b0;
      end
    end else if (adv) begin
      s1     <= s1_next;
      s2     <= s2_next;
      numx   <= numx_next;
      numy   <= numy_next;
      denx   <= denx_next;
      deny   <= deny_next;
      dl1[0] <= s2;
      for (int k = 1; k < rdu_pkg::DIV_LAT; k++) begin
        dl1[k] <= dl1[k-1];
      end
      s4     <= s4_next;
      s5     <= s5_next;
      s6     <= s6_next;
      s7     <= s7_next;
      s8     <= s8_next;
      dl2[0] <= s8.sd;
      for (int k = 1; k < rdu_pkg::DIV_LAT; k++) begin
        dl2[k] <= dl2[k-1];
      end
      out_valid <= dl2[rdu_pkg::DIV_LAT-1].v;
      dpos_dx   <= dpos_dx_next;
      dpos_dy   <= dpos_dy_next;
      du_dx     <= du_dx_next;
      dv_dx     <= dv_dx_next;
      du_dy     <= du_dy_next;
      dv_dy     <= dv_dy_next;
      status    <= status_next;
    end
  end

endmodule

@@ sv/rdu_div.sv @@
module rdu_div (
  input  logic                               clk,
  input  logic                               adv,
  input  logic signed [rdu_pkg::DIV_NW-1:0]  num,
  input  logic signed [rdu_pkg::DIV_DW-1:0]  den,
  output logic signed [rdu_pkg::DIV_QB:0]    quo,
  output logic                               neg,
  output logic                               ovf
);

  logic [rdu_pkg::DIV_NM-1:0] magn;
  logic [rdu_pkg::DIV_DM-1:0] magd;

  logic [rdu_pkg::DIV_NM-1:0] mn  [rdu_pkg::DIV_QB+1];
  logic [rdu_pkg::DIV_DM-1:0] md  [rdu_pkg::DIV_QB+1];
  logic [rdu_pkg::DIV_DM-1:0] rem [rdu_pkg::DIV_QB+1];
  logic [rdu_pkg::DIV_QB-1:0] qa  [rdu_pkg::DIV_QB+1];
  logic                       ng  [rdu_pkg::DIV_QB+1];
  logic                       ov  [rdu_pkg::DIV_QB+1];

  // Take magnitudes of both operands
  always_comb begin
    magn = num[rdu_pkg::DIV_NW-1] ? rdu_pkg::DIV_NM'(-num) : rdu_pkg::DIV_NM'(num);
    magd = den[rdu_pkg::DIV_DW-1] ? rdu_pkg::DIV_DM'(-den) : rdu_pkg::DIV_DM'(den);
  end

  // Prepare: flag a quotient too wide for the step chain, load the top remainder
  always_ff @(posedge clk) begin
    if (adv) begin
      mn[0]  <= magn;
      md[0]  <= magd;
      rem[0] <= rdu_pkg::DIV_DM'(magn >> rdu_pkg::DIV_QB);
      qa[0]  <= '0;
      ng[0]  <= num[rdu_pkg::DIV_NW-1] ^ den[rdu_pkg::DIV_DW-1];
      ov[0]  <= (magn >> rdu_pkg::DIV_QB) >= rdu_pkg::DIV_NM'(magd);
    end
  end

  // One restoring step per stage, most significant quotient bit first
  for (genvar k = 0; k < rdu_pkg::DIV_QB; k++) begin : g_step
    logic [rdu_pkg::DIV_DM:0] trial;
    logic                     ge;

    always_comb begin
      trial = {rem[k], mn[k][rdu_pkg::DIV_QB-1-k]};
      ge    = trial >= {1'b0, md[k]};
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        mn[k+1]  <= mn[k];
        md[k+1]  <= md[k];
        rem[k+1] <= ge ? rdu_pkg::DIV_DM'(trial - {1'b0, md[k]}) : trial[rdu_pkg::DIV_DM-1:0];
        qa[k+1]  <= {qa[k][rdu_pkg::DIV_QB-2:0], ge};
        ng[k+1]  <= ng[k];
        ov[k+1]  <= ov[k];
      end
    end
  end

  // Apply sign, truncating toward zero
  always_comb begin
    quo = ng[rdu_pkg::DIV_QB] ? -$signed({1'b0, qa[rdu_pkg::DIV_QB]})
                              :  $signed({1'b0, qa[rdu_pkg::DIV_QB]});
    neg = ng[rdu_pkg::DIV_QB];
    ovf = ov[rdu_pkg::DIV_QB];
  end

endmodule
